// ===== sv/csrre_pkg.sv =====
// Shared types and constants for the CSR binary sparse-by-dense row engine.
package csrre_pkg;

  localparam int DENSE_ROWS     = 1024;
  localparam int MAX_DENSE_COLS = 16;

  localparam int ROW_AW  = $clog2(DENSE_ROWS);
  localparam int COL_W   = $clog2(MAX_DENSE_COLS);
  localparam int CNT_W   = $clog2(MAX_DENSE_COLS + 1);
  localparam int WORD_W  = 32;
  localparam int CFG_W   = 5;

  localparam int LOAD_ROW_W = 10;
  localparam int LOAD_COL_W = 4;
  localparam int NZ_COL_W   = 10;
  localparam int REQ_W      = 2;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NZ    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EMPTY = 2'd2;

  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(MAX_DENSE_COLS);

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [MAX_DENSE_COLS-1:0] row_t;

  // Control that travels with an item from the read stage to the accumulator.
  typedef struct packed {
    logic add;
    logic flush;
  } acc_ctl_t;

  // Clamp the configured column count to 1..MAX_DENSE_COLS.
  function automatic logic [CNT_W-1:0] cols_in_use(input logic [CFG_W-1:0] cfg);
    logic [CNT_W-1:0] n;
    if (cfg == '0) begin
      n = CNT_W'(1);
    end else if (32'(cfg) > MAX_DENSE_COLS) begin
      n = CNT_W'(MAX_DENSE_COLS);
    end else begin
      n = CNT_W'(cfg);
    end
    return n;
  endfunction

endpackage

// ===== sv/csrre_store.sv =====
// Dense matrix store: one bank per column, element writes, whole-row reads.
module csrre_store
  import csrre_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ROW_AW-1:0] wr_row,
  input  logic [COL_W-1:0]  wr_col,
  input  word_t             wr_data,
  input  logic              rd_en,
  input  logic [ROW_AW-1:0] rd_row,
  output row_t              rd_data_r
);

  for (genvar c = 0; c < MAX_DENSE_COLS; c++) begin : g_bank
    word_t bank_mem [DENSE_ROWS];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_col == COL_W'(c))) begin
        bank_mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
        rd_data_r[c] <= bank_mem[rd_row];
      end
    end
  end

endmodule

// ===== sv/csrre_acc.sv =====
// Row accumulator stage: adds the fetched dense row and hands off finished rows.
module csrre_acc
  import csrre_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_valid,
  input  acc_ctl_t item_ctl,
  input  row_t     rd_data,
  input  logic     drain_busy,
  output logic     stall,
  output logic     flush_valid,
  output row_t     flush_row
);

  logic     s1_valid_r, s1_valid_nxt;
  acc_ctl_t s1_ctl_r, s1_ctl_nxt;
  row_t     acc_r, acc_nxt;
  row_t     sum;
  logic     fire;

  // A closing item waits here while the previous row is still draining.
  assign stall = s1_valid_r && s1_ctl_r.flush && drain_busy;
  assign fire  = s1_valid_r && !stall;

  always_comb begin
    for (int c = 0; c < MAX_DENSE_COLS; c++) begin
      sum[c] = s1_ctl_r.add ? acc_r[c] + rd_data[c] : acc_r[c];
    end
  end

  assign flush_valid = fire && s1_ctl_r.flush;
  assign flush_row   = sum;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_ctl_nxt   = s1_ctl_r;
    acc_nxt      = acc_r;
    if (!stall) begin
      s1_valid_nxt = item_valid;
      s1_ctl_nxt   = item_ctl;
    end
    if (fire) begin
      acc_nxt = s1_ctl_r.flush ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_ctl_r   <= '0;
      acc_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_ctl_r   <= s1_ctl_nxt;
      acc_r      <= acc_nxt;
    end
  end

endmodule

// ===== sv/csrre_drain.sv =====
// Output drain: holds one finished row and sends its active columns a word at a time.
module csrre_drain
  import csrre_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  row_t             load_row,
  input  logic [CNT_W-1:0] load_cnt,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [COL_W-1:0] out_col,
  output word_t            out_value,
  output logic             out_last
);

  logic             busy_r, busy_nxt;
  row_t             row_r, row_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [COL_W-1:0] idx_r, idx_nxt;
  logic             take;

  assign busy      = busy_r;
  assign out_valid = busy_r;
  assign out_col   = idx_r;
  assign out_value = row_r[0];
  assign out_last  = (CNT_W'(idx_r) + CNT_W'(1)) == cnt_r;
  assign take      = busy_r && out_ready;

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      row_nxt  = load_row;
      cnt_nxt  = load_cnt;
      idx_nxt  = '0;
    end else if (take) begin
      // The current column always sits in the bottom slot.
      for (int c = 0; c < MAX_DENSE_COLS - 1; c++) begin
        row_nxt[c] = row_r[c+1];
      end
      row_nxt[MAX_DENSE_COLS-1] = '0;
      idx_nxt = idx_r + COL_W'(1);
      if (out_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
    end
    row_r <= row_nxt;
  end

endmodule

// ===== sv/csr_binary_spmm_row_engine_unit.sv =====
// Top level of the CSR binary sparse-by-dense row engine.
// Load words and nonzeros without a row end are taken one per cycle while no
// closing word stalls. A row-closing word gives one result per cycle for the active
// column count while out_tready is high; a second closing word waits until the
// previous row has drained. Reset clears the accumulator and sets the column count
// to 16; the dense store is not cleared and reads undefined until written.
module csr_binary_spmm_row_engine_unit
  import csrre_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,   // active_dense_cols
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // load_row, load_col, load_value, nz_col
  input  logic [REQ_W-1:0]       in_tuser,    // req_type
  input  logic                   in_tlast,    // row_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // out_col, out_value, zero pad
  output logic                   out_tlast    // last
);

  logic [CFG_W-1:0]      cols_cfg_r;
  logic                  accept;
  logic [LOAD_ROW_W-1:0] load_row;
  logic [LOAD_COL_W-1:0] load_col;
  word_t                 load_value;
  logic [NZ_COL_W-1:0]   nz_col;
  logic                  is_load, is_nz, is_empty;
  logic                  load_ok, nz_ok;
  logic                  item_valid;
  acc_ctl_t              item_ctl;
  row_t                  rd_data;
  logic                  stall;
  logic                  flush_valid;
  row_t                  flush_row;
  logic                  drain_busy;
  logic [COL_W-1:0]      res_col;
  word_t                 res_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= COLS_RESET;
    end else if (cfg_we) begin
      cols_cfg_r <= cfg_wdata;
    end
  end

  assign load_row   = in_tdata[9:0];
  assign load_col   = in_tdata[13:10];
  assign load_value = in_tdata[45:14];
  assign nz_col     = in_tdata[55:46];

  assign in_tready = !stall;
  assign accept    = in_tvalid && in_tready;

  assign is_load  = in_tuser == REQ_LOAD;
  assign is_nz    = in_tuser == REQ_NZ;
  assign is_empty = in_tuser == REQ_EMPTY;

  assign load_ok = (32'(load_row) < DENSE_ROWS) && (32'(load_col) < MAX_DENSE_COLS);
  assign nz_ok   = 32'(nz_col) < DENSE_ROWS;

  assign item_valid     = accept && (is_nz || is_empty);
  assign item_ctl.add   = is_nz && nz_ok;
  assign item_ctl.flush = is_empty || (is_nz && in_tlast);

  csrre_store u_store (
    .clk       (clk),
    .wr_en     (accept && is_load && load_ok),
    .wr_row    (ROW_AW'(load_row)),
    .wr_col    (COL_W'(load_col)),
    .wr_data   (load_value),
    .rd_en     (accept && is_nz && nz_ok),
    .rd_row    (ROW_AW'(nz_col)),
    .rd_data_r (rd_data)
  );

  csrre_acc u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_ctl    (item_ctl),
    .rd_data     (rd_data),
    .drain_busy  (drain_busy),
    .stall       (stall),
    .flush_valid (flush_valid),
    .flush_row   (flush_row)
  );

  csrre_drain u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (flush_valid),
    .load_row  (flush_row),
    .load_cnt  (cols_in_use(cols_cfg_r)),
    .busy      (drain_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_col   (res_col),
    .out_value (res_value),
    .out_last  (out_tlast)
  );

  assign out_tdata = {4'b0, res_value, res_col};

endmodule

// ===== sim/csr_binary_spmm_row_engine_unit_tb.sv =====
// Self-checking testbench for the CSR binary sparse-by-dense row engine.
`timescale 1ns / 1ps

module csr_binary_spmm_row_engine_unit_tb;
  import csrre_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 18;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [COL_W-1:0] col;
    word_t            value;
    logic             lst;
  } row_word_t;

  class spmm_scoreboard;
    word_t           dense_copy [DENSE_ROWS*MAX_DENSE_COLS];
    word_t           row_sum [MAX_DENSE_COLS];
    int              cols_used;
    row_word_t       pending_q [$];
    int              errors;
    int              words_in;
    int              words_out;
    int              rows_closed;

    function new();
      foreach (row_sum[c]) row_sum[c] = '0;
      cols_used = MAX_DENSE_COLS;
      errors = 0;
      words_in = 0;
      words_out = 0;
      rows_closed = 0;
    endfunction

    function void set_cols(logic [CFG_W-1:0] v);
      if (v == '0) cols_used = 1;
      else if (int'(v) > MAX_DENSE_COLS) cols_used = MAX_DENSE_COLS;
      else cols_used = int'(v);
    endfunction

    function void close_row();
      row_word_t w;
      for (int c = 0; c < cols_used; c++) begin
        w.col = COL_W'(c);
        w.value = row_sum[c];
        w.lst = (c == cols_used - 1);
        pending_q.push_back(w);
      end
      foreach (row_sum[c]) row_sum[c] = '0;
      rows_closed++;
    endfunction

    function void note_input(logic [REQ_W-1:0] req, logic [IN_TDATA_W-1:0] data,
                             logic rend);
      logic [9:0]  lrow;
      logic [3:0]  lcol;
      word_t       lval;
      logic [9:0]  nzc;
      lrow = data[9:0];
      lcol = data[13:10];
      lval = data[45:14];
      nzc  = data[55:46];
      words_in++;
      case (req)
        REQ_LOAD: begin
          dense_copy[int'(lrow) * MAX_DENSE_COLS + int'(lcol)] = lval;
        end
        REQ_NZ: begin
          for (int c = 0; c < MAX_DENSE_COLS; c++)
            row_sum[c] += dense_copy[int'(nzc) * MAX_DENSE_COLS + c];
          if (rend) close_row();
        end
        REQ_EMPTY: close_row();
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] data, logic lst);
      row_word_t w;
      words_out++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected word col=%0d value=%h", data[3:0], data[35:4]));
      end else begin
        w = pending_q.pop_front();
        if (data[3:0] !== w.col)
          report($sformatf("col got %0d want %0d", data[3:0], w.col));
        if (data[35:4] !== w.value)
          report($sformatf("col %0d value got %h want %h", w.col, data[35:4], w.value));
        if (lst !== w.lst)
          report($sformatf("col %0d last got %b want %b", w.col, lst, w.lst));
        if (data[39:36] !== 4'd0)
          report($sformatf("col %0d pad bits got %h", w.col, data[39:36]));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]       in_tuser = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  spmm_scoreboard sb = new();
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             cycle_count = 0;
  int             settings_used = 1;
  logic [15:0]    loaded_cols [DENSE_ROWS];
  int             full_rows [$];

  csr_binary_spmm_row_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending",
               cycle_count, sb.pending_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  task automatic send_word(logic [REQ_W-1:0] req, logic [9:0] lrow, logic [3:0] lcol,
                           word_t lval, logic [9:0] nzc, logic rend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tlast  <= rend;
    in_tdata  <= {nzc, lval, lcol, lrow};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (req == REQ_LOAD) begin
      loaded_cols[lrow][lcol] = 1'b1;
      if (loaded_cols[lrow] == 16'hFFFF && !(int'(lrow) inside {full_rows}))
        full_rows.push_back(int'(lrow));
    end
  endtask

  task automatic load_full_row(logic [9:0] row);
    for (int c = 0; c < MAX_DENSE_COLS; c++)
      send_word(REQ_LOAD, row, 4'(c), $urandom, 10'($urandom), 1'($urandom));
  endtask

  // Mostly well-formed rows: loads into rows that are fully known, nonzeros
  // that only touch fully loaded dense rows, plus empties and unused selectors.
  task automatic random_word();
    int          pick;
    logic [9:0]  row;
    pick = $urandom_range(99);
    if (pick < 25) begin
      if ($urandom_range(4) == 0) row = 10'($urandom);
      else row = 10'(full_rows[$urandom_range(full_rows.size() - 1)]);
      send_word(REQ_LOAD, row, 4'($urandom), $urandom, 10'($urandom), 1'($urandom));
    end else if (pick < 80) begin
      row = 10'(full_rows[$urandom_range(full_rows.size() - 1)]);
      send_word(REQ_NZ, 10'($urandom), 4'($urandom), $urandom, row,
                ($urandom_range(99) < 35));
    end else if (pick < 95) begin
      send_word(REQ_EMPTY, 10'($urandom), 4'($urandom), $urandom, 10'($urandom),
                1'($urandom));
    end else begin
      send_word(REQ_UNUSED, 10'($urandom), 4'($urandom), $urandom, 10'($urandom),
                1'($urandom));
    end
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cols(logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_cols(v);
    settings_used++;
  endtask

  initial begin
    logic [CFG_W-1:0] phase_cols [6];
    word_t            corner_vals [5];
    foreach (loaded_cols[r]) loaded_cols[r] = '0;
    phase_cols[0] = 5'd1;
    phase_cols[1] = 5'd31;
    phase_cols[2] = 5'd0;
    phase_cols[3] = 5'($urandom_range(2, 15));
    phase_cols[4] = 5'd16;
    phase_cols[5] = 5'($urandom_range(17, 30));
    corner_vals[0] = 32'h7FFF_FFFF;
    corner_vals[1] = 32'h8000_0000;
    corner_vals[2] = 32'hFFFF_FFFF;
    corner_vals[3] = 32'h0000_0000;
    corner_vals[4] = 32'h0000_0001;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset column count: extreme values that wrap when
    // summed twice, stray row ends, an unused selector, and an empty row that
    // closes a row with open nonzeros.
    for (int c = 0; c < MAX_DENSE_COLS; c++)
      send_word(REQ_LOAD, 10'd0, 4'(c), (c < 5) ? corner_vals[c] : $urandom, 10'd1023,
                1'b0);
    send_word(REQ_NZ, 10'd1023, 4'd15, 32'hFFFF_FFFF, 10'd0, 1'b0);
    send_word(REQ_NZ, 10'd0, 4'd0, 32'd0, 10'd0, 1'b1);
    send_word(REQ_EMPTY, 10'd1023, 4'd15, 32'hFFFF_FFFF, 10'd1023, 1'b1);
    send_word(REQ_LOAD, 10'd0, 4'd5, 32'h8000_0000, 10'd0, 1'b1);
    send_word(REQ_UNUSED, 10'd1023, 4'd15, 32'hFFFF_FFFF, 10'd1023, 1'b1);
    send_word(REQ_NZ, 10'd0, 4'd0, 32'd0, 10'd0, 1'b0);
    send_word(REQ_EMPTY, 10'd0, 4'd0, 32'd0, 10'd0, 1'b0);

    load_full_row(10'd1023);
    load_full_row(10'($urandom_range(1, 1022)));
    for (int i = 0; i < PHASE_WORDS; i++) random_word();
    in_tvalid <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      drain();
      write_cols(phase_cols[p]);
      case (p % 4)
        0: begin send_idle_pct = 77; recv_stall_pct = 0; end
        1: begin send_idle_pct = 0; recv_stall_pct = 77; end
        2: begin send_idle_pct = 21; recv_stall_pct = 21; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) random_word();
      in_tvalid <= 1'b0;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d input words and %0d closed rows under %0d column settings,",
             sb.words_in, sb.rows_closed, settings_used);
    $display("with %0d result words checked and %0d mismatches.", sb.words_out, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== csr_binary_spmm_row_engine_unit.f =====
sv/csrre_pkg.sv
sv/csrre_store.sv
sv/csrre_acc.sv
sv/csrre_drain.sv
sv/csr_binary_spmm_row_engine_unit.sv
sim/csr_binary_spmm_row_engine_unit_tb.sv
